// ===== design/jspi_pkg.sv =====
// ----------------------------------------------------------------------------
// Joint-space profile interpolator package
// Shared types, constants and the microcode program of the tick sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package jspi_pkg;

  // Configuration defaults and limits.
  localparam int JOINTS_DEF = 6;
  localparam int MAX_STEPS  = 4096;

  // Stream and configuration port widths.
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_END = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL_BEG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT = 3'd5;

  // Progress value of a finished move, Q1.30.
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Motion phase codes.
  localparam logic [1:0] PHASE_UP     = 2'd0;
  localparam logic [1:0] PHASE_CRUISE = 2'd1;
  localparam logic [1:0] PHASE_DOWN   = 2'd2;

  // Microcode address width and entry points.
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_START  = 4'd0;
  localparam logic [UPC_W-1:0] UPC_CRUISE = 4'd5;
  localparam logic [UPC_W-1:0] UPC_JOINT  = 4'd7;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_XX   = 3'd1,
    MUL_SQ   = 3'd2,
    MUL_CHI  = 3'd3,
    MUL_CLO  = 3'd4,
    MUL_RATE = 3'd5,
    MUL_SPAN = 3'd6
  } mul_sel_t;

  // Use made of the registered product.
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_LO     = 3'd1,
    ACT_QHI    = 3'd2,
    ACT_QUART  = 3'd3,
    ACT_CRUISE = 3'd4,
    ACT_EMIT   = 3'd5
  } act_t;

  // Sequencer branch condition.
  typedef enum logic [1:0] {
    COND_NEXT   = 2'd0,
    COND_JUMP   = 2'd1,
    COND_CRUISE = 2'd2,
    COND_LOOP   = 2'd3
  } cond_t;

  typedef struct packed {
    mul_sel_t         mul;
    act_t             act;
    cond_t            cond;
    logic             wait_out;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  // Status from the datapath that steers the sequencer.
  typedef struct packed {
    logic cruise;
    logic more;
    logic out_free;
  } seq_status_t;

  localparam ctrl_word_t CW_IDLE = '{mul: MUL_NONE, act: ACT_NONE, cond: COND_NEXT,
                                     wait_out: 1'b0, target: UPC_START};

  // Tick program. The product of a step is used by the step after it.
  function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] addr);
    ctrl_word_t cw;
    cw = CW_IDLE;
    unique case (addr)
      // x squared; cruise ticks branch off.
      4'd0: begin
        cw.mul    = MUL_XX;
        cw.cond   = COND_CRUISE;
        cw.target = UPC_CRUISE;
      end
      // x to the fourth.
      4'd1: cw.mul = MUL_SQ;
      // Coefficient times upper half of x^4, keep lower half.
      4'd2: begin
        cw.mul = MUL_CHI;
        cw.act = ACT_LO;
      end
      // Coefficient times lower half of x^4.
      4'd3: begin
        cw.mul = MUL_CLO;
        cw.act = ACT_QHI;
      end
      // Combine the halves into ramp progress.
      4'd4: begin
        cw.act    = ACT_QUART;
        cw.cond   = COND_JUMP;
        cw.target = UPC_JOINT;
      end
      // Cruise rate times step.
      4'd5: cw.mul = MUL_RATE;
      4'd6: cw.act = ACT_CRUISE;
      // Progress times joint span.
      4'd7: cw.mul = MUL_SPAN;
      // Emit one angle, loop over the joints.
      4'd8: begin
        cw.act      = ACT_EMIT;
        cw.cond     = COND_LOOP;
        cw.wait_out = 1'b1;
        cw.target   = UPC_JOINT;
      end
      default: cw = CW_IDLE;
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ===== design/jspi_seq.sv =====
// ----------------------------------------------------------------------------
// Joint-space profile interpolator sequencer
// Step counter over the microcode table, with conditional jumps and a hold
// while the result register is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module jspi_seq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire jspi_pkg::seq_status_t status,
  output jspi_pkg::ctrl_word_t      ctrl,
  output logic                      busy
);
  import jspi_pkg::*;

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  ctrl_word_t       cw;

  // Next step selection.
  always_comb begin
    cw       = ucode(upc_r);
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        upc_nxt  = UPC_START;
      end
    end else if (cw.wait_out && !status.out_free) begin
      upc_nxt = upc_r;
    end else begin
      unique case (cw.cond)
        COND_NEXT:   upc_nxt = upc_r + 1'b1;
        COND_JUMP:   upc_nxt = cw.target;
        COND_CRUISE: upc_nxt = status.cruise ? cw.target : upc_r + 1'b1;
        COND_LOOP: begin
          if (status.more) begin
            upc_nxt = cw.target;
          end else begin
            busy_nxt = 1'b0;
            upc_nxt  = UPC_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= UPC_START;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  assign ctrl = busy_r ? cw : CW_IDLE;
  assign busy = busy_r;

endmodule

`default_nettype wire

// ===== design/joint_space_profile_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// Joint-space profile interpolator
// Trapezoidal progress profile (quartic ramps, linear cruise) applied to the
// stored endpoints of each joint, one angle per joint for each tick.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+----------------------------------
//  in_     | input     | tvalid / tready  | tdata: endpoints, step; tuser: kind
//  out_    | output    | tvalid / tready  | tdata: joint, angle, progress, phase
//  cfg_    | input     | we, no wait      | index, wdata
//
//  A load transaction leaves the block idle. A tick runs the quartic steps
//  in a ramp phase or the linear steps in cruise, then a multiply and an
//  emit step per joint, on the one shared 32x32 multiplier. A tick past the
//  move end is dropped. Output stalls hold the emitting step.
//  Reset restores the register defaults and clears all joint endpoints.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_space_profile_interpolator_top #(
  parameter int JOINTS = jspi_pkg::JOINTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // joint_index[2:0], start_angle[34:3], target_angle[66:35], step_index[78:67]
  input  wire logic [jspi_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  wire logic                             in_tuser,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // out_joint[2:0], angle[34:3], progress[65:35], phase[67:66]
  output logic [jspi_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic                             cfg_we,
  input  wire logic [jspi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [jspi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import jspi_pkg::*;

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // Configuration registers.
  logic [12:0] total_r, accel_r, decel_r;
  logic [31:0] coef_r;
  logic [30:0] rate_r;
  logic [31:0] cint_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= 13'd1000;
      accel_r <= 13'd200;
      decel_r <= 13'd800;
      coef_r  <= '0;
      rate_r  <= '0;
      cint_r  <= '0;
    end else if (cfg_we) begin
      priority case (cfg_index)
        CFG_TOTAL:     total_r <= cfg_wdata[12:0];
        CFG_ACCEL_END: accel_r <= cfg_wdata[12:0];
        CFG_DECEL_BEG: decel_r <= cfg_wdata[12:0];
        CFG_COEF:      coef_r  <= cfg_wdata;
        CFG_RATE:      rate_r  <= cfg_wdata[30:0];
        CFG_INTERCEPT: cint_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input field unpacking.
  logic [2:0]  in_joint;
  logic [31:0] in_start, in_end;
  logic [11:0] in_step;
  assign in_joint = in_tdata[2:0];
  assign in_start = in_tdata[34:3];
  assign in_end   = in_tdata[66:35];
  assign in_step  = in_tdata[78:67];

  logic        busy;
  logic        in_fire, start;
  logic [12:0] n_eff;
  logic [12:0] step_ext;

  // No transaction is taken while reset is held.
  assign in_tready = rst_n && !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign n_eff     = (32'(total_r) > MAX_STEPS) ? 13'(MAX_STEPS) : total_r;
  assign step_ext  = {1'b0, in_step};
  assign start     = in_fire && in_tuser && (step_ext < n_eff);

  // Joint endpoint store: start angle, span sign and span magnitude.
  logic [31:0] jstart_r [JOINTS];
  logic        jneg_r   [JOINTS];
  logic [31:0] jmag_r   [JOINTS];
  logic        load_en;
  logic        span_neg;
  logic [31:0] span_mag;

  assign load_en  = in_fire && !in_tuser && (32'(in_joint) < JOINTS);
  assign span_neg = $signed(in_end) < $signed(in_start);
  assign span_mag = span_neg ? (in_start - in_end) : (in_end - in_start);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < JOINTS; i++) begin
        jstart_r[i] <= '0;
        jneg_r[i]   <= 1'b0;
        jmag_r[i]   <= '0;
      end
    end else if (load_en) begin
      jstart_r[in_joint[JW-1:0]] <= in_start;
      jneg_r[in_joint[JW-1:0]]   <= span_neg;
      jmag_r[in_joint[JW-1:0]]   <= span_mag;
    end
  end

  // Tick context captured at acceptance.
  logic [11:0] s_r;
  logic [12:0] x_r;
  logic [1:0]  phase_r;

  always_ff @(posedge clk) begin
    if (start) begin
      s_r <= in_step;
      if (step_ext < accel_r) begin
        phase_r <= PHASE_UP;
        x_r     <= step_ext;
      end else if (step_ext < decel_r) begin
        phase_r <= PHASE_CRUISE;
        x_r     <= step_ext;
      end else begin
        phase_r <= PHASE_DOWN;
        x_r     <= n_eff - step_ext;
      end
    end
  end

  // Sequencer.
  ctrl_word_t  ctrl;
  seq_status_t status;
  logic [JW-1:0] j_r;
  logic        out_valid_r;
  logic        emit;

  assign status.cruise   = (phase_r == PHASE_CRUISE);
  assign status.more     = (j_r != JW'(JOINTS - 1));
  assign status.out_free = !out_valid_r || out_tready;

  jspi_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // Quartic partial results and progress.
  logic [23:0] lo_r;
  logic [56:0] qhi_r;
  logic [30:0] prog_r, prog_nxt;
  logic [57:0] qsum;
  logic [33:0] qval;
  logic [44:0] csum;

  // Shared multiplier operand selection.
  logic [63:0] prod_r;
  logic [31:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul)
      MUL_XX: begin
        mul_a = 32'(x_r);
        mul_b = 32'(x_r);
      end
      MUL_SQ: begin
        mul_a = 32'(prod_r[24:0]);
        mul_b = 32'(prod_r[24:0]);
      end
      MUL_CHI: begin
        mul_a = coef_r;
        mul_b = 32'(prod_r[48:24]);
      end
      MUL_CLO: begin
        mul_a = coef_r;
        mul_b = 32'(lo_r);
      end
      MUL_RATE: begin
        mul_a = 32'(rate_r);
        mul_b = 32'(s_r);
      end
      MUL_SPAN: begin
        mul_a = 32'(prog_r);
        mul_b = jmag_r[j_r];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul != MUL_NONE) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
    end
  end

  // Combine the quartic halves and clamp the progress.
  assign qsum = 58'(qhi_r) + 58'(prod_r[55:24]);
  assign qval = qsum[57:24];
  assign csum = {{13{cint_r[31]}}, cint_r} + {2'b00, prod_r[42:0]};

  always_comb begin
    prog_nxt = prog_r;
    if (ctrl.act == ACT_QUART) begin
      if (phase_r == PHASE_UP) begin
        prog_nxt = (qval > 34'(ONE_Q30)) ? ONE_Q30 : qval[30:0];
      end else begin
        prog_nxt = (qval >= 34'(ONE_Q30)) ? '0 : ONE_Q30 - qval[30:0];
      end
    end else if (ctrl.act == ACT_CRUISE) begin
      if (csum[44]) begin
        prog_nxt = '0;
      end else if (csum[43:0] > 44'(ONE_Q30)) begin
        prog_nxt = ONE_Q30;
      end else begin
        prog_nxt = csum[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_LO) begin
      lo_r <= prod_r[23:0];
    end
    if (ctrl.act == ACT_QHI) begin
      qhi_r <= prod_r[56:0];
    end
    prog_r <= prog_nxt;
  end

  // Angle of the current joint: start plus floor(progress * span / 2^30).
  logic [62:0] pm_adj;
  logic [31:0] delta;
  logic [31:0] angle;

  assign pm_adj = jneg_r[j_r] ? (63'(prod_r[61:0]) + 63'(32'h3FFF_FFFF))
                              : 63'(prod_r[61:0]);
  assign delta  = pm_adj[61:30];
  assign angle  = jneg_r[j_r] ? (jstart_r[j_r] - delta) : (jstart_r[j_r] + delta);

  assign emit = (ctrl.act == ACT_EMIT) && status.out_free;

  // Joint counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r <= '0;
    end else if (start) begin
      j_r <= '0;
    end else if (emit && status.more) begin
      j_r <= j_r + 1'b1;
    end
  end

  // Result register.
  logic [2:0]  oj_r;
  logic [31:0] oangle_r;
  logic [30:0] oprog_r;
  logic [1:0]  ophase_r;
  logic        olast_r;
  logic        out_valid_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oj_r     <= 3'(j_r);
      oangle_r <= angle;
      oprog_r  <= prog_r;
      ophase_r <= phase_r;
      olast_r  <= !status.more;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {4'b0000, ophase_r, oprog_r, oangle_r, oj_r};

endmodule

`default_nettype wire

// ===== design/jspi_chk.sv =====
// ----------------------------------------------------------------------------
// Joint-space profile interpolator checker
// Port-level properties of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jspi_chk #(
  parameter int JOINTS = jspi_pkg::JOINTS_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tuser,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [jspi_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                             out_tlast,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready
);
  import jspi_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // While a tick still has joints to emit, no new transaction is taken.
  a_busy_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input accepted in the middle of a tick");

  // A load transaction never blocks the input.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> in_tready)
    else $error("load left the block busy");

  // The last flag marks exactly the highest joint.
  a_last_joint: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[2:0] == 3'(JOINTS - 1))))
    else $error("last flag does not match the joint number");

  // Progress stays within the clamp range.
  a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[65:35] <= ONE_Q30))
    else $error("progress above one");

endmodule

bind joint_space_profile_interpolator_top jspi_chk #(.JOINTS(JOINTS)) u_jspi_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tuser   (in_tuser),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

// ===== tb/tb_joint_space_profile_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// Joint-space profile interpolator testbench
// Loads joint endpoints, sends step ticks under a series of profile settings
// and compares every emitted joint angle against a predictor of the quartic
// ramp, linear cruise and quartic ramp-down progress profile. Both stream
// sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_joint_space_profile_interpolator_top;
  import jspi_pkg::*;

  // Request kinds carried on in_tuser.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Register indexes past the end of the register file.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam int SETTLE_CYCLES  = 40;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int BACKLOG_AT     = 200;
  localparam int BACKLOG_CYCLES = 400;
  localparam int MOVE_ITEMS     = 33;
  localparam int MOVES          = 10;

  // One emitted joint angle.
  typedef struct {
    logic [2:0]  jnt;
    logic [31:0] angle;
    logic [30:0] progress;
    logic [1:0]  phase;
    logic        last;
  } joint_angle_t;

  // Predicts the angles of each tick and checks them in order.
  class joint_angle_scoreboard;
    longint unsigned move_len    = 1000;
    longint unsigned ramp_end    = 200;
    longint unsigned brake_start = 800;
    longint unsigned quart_gain  = 0;
    longint unsigned cruise_gain = 0;
    longint          cruise_base = 0;
    longint          start_pos [JOINTS_DEF];
    longint          travel [JOINTS_DEF];
    joint_angle_t    pending_angles [$];
    int              failures    = 0;
    int              angles_seen = 0;

    // Register write; unknown indexes leave the profile unchanged.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_TOTAL:     move_len    = val[12:0];
        CFG_ACCEL_END: ramp_end    = val[12:0];
        CFG_DECEL_BEG: brake_start = val[12:0];
        CFG_COEF:      quart_gain  = val;
        CFG_RATE:      cruise_gain = val[30:0];
        CFG_INTERCEPT: cruise_base = signed'(val);
        default: ;
      endcase
    endfunction

    // floor(gain * x^4 / 2^48), split so that no product overflows.
    function longint unsigned ramp_progress(longint unsigned x);
      longint unsigned x2;
      longint unsigned x4;
      x2 = x * x;
      x4 = x2 * x2;
      return (quart_gain * (x4 >> 24) + ((quart_gain * (x4 & 64'hFF_FFFF)) >> 24)) >> 24;
    endfunction

    // Accepted input transaction: store endpoints or expect one angle per joint.
    function void note_request(logic kind, logic [IN_TDATA_W-1:0] data);
      logic [2:0]      jnt;
      longint          st;
      longint          en;
      longint unsigned s;
      longint unsigned n;
      longint          prog;
      longint          p;
      longint          a;
      logic [1:0]      ph;
      joint_angle_t    r;
      jnt = data[2:0];
      if (kind == REQ_LOAD) begin
        if (jnt < JOINTS_DEF) begin
          st = signed'(data[34:3]);
          en = signed'(data[66:35]);
          start_pos[jnt] = st;
          travel[jnt]    = en - st;
        end
        return;
      end
      s = data[78:67];
      n = (move_len > MAX_STEPS) ? MAX_STEPS : move_len;
      if (s >= n) return;
      if (s < ramp_end) begin
        ph   = PHASE_UP;
        prog = longint'(ramp_progress(s));
      end else if (s < brake_start) begin
        ph   = PHASE_CRUISE;
        prog = cruise_base + longint'(cruise_gain * s);
      end else begin
        ph   = PHASE_DOWN;
        prog = longint'(ONE_Q30) - longint'(ramp_progress(n - s));
      end
      if (prog < 0) prog = 0;
      if (prog > longint'(ONE_Q30)) prog = longint'(ONE_Q30);
      for (int j = 0; j < JOINTS_DEF; j++) begin
        // Arithmetic shift gives the floor of the scaled travel.
        p = prog * travel[j];
        a = start_pos[j] + (p >>> 30);
        r.jnt      = j[2:0];
        r.angle    = a[31:0];
        r.progress = prog[30:0];
        r.phase    = ph;
        r.last     = (j == JOINTS_DEF - 1);
        pending_angles.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [31:0] expv, logic [31:0] gotv);
      if (expv !== gotv) begin
        $display("%0t: %s expected %h, actual %h", $time, name, expv, gotv);
        failures++;
      end
    endfunction

    // Accepted output transaction against the oldest expected angle.
    function void check_angle(logic [OUT_TDATA_W-1:0] data, logic tlast);
      joint_angle_t want;
      angles_seen++;
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected angle, expected none, actual joint %0d angle %h",
                 $time, data[2:0], data[34:3]);
        failures++;
        return;
      end
      want = pending_angles.pop_front();
      compare_field("joint", 32'(want.jnt), 32'(data[2:0]));
      compare_field("angle", want.angle, data[34:3]);
      compare_field("progress", 32'(want.progress), 32'(data[65:35]));
      compare_field("phase", 32'(want.phase), 32'(data[67:66]));
      compare_field("last", 32'(want.last), 32'(tlast));
    endfunction
  endclass

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;
  logic                    in_tuser   = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata  = '0;

  joint_angle_scoreboard sb;
  bit quiet        = 1'b0;
  bit backlog_done = 1'b0;
  int hold_left    = 0;
  int stall_left   = 0;
  int cycles       = 0;

  joint_space_profile_interpolator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Output side: check accepted angles, then decide the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_angle(out_tdata, out_tlast);
    if (!backlog_done && sb.angles_seen >= BACKLOG_AT) begin
      backlog_done = 1'b1;
      hold_left    = BACKLOG_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offer one input transaction and wait for it to be taken, then maybe idle.
  task automatic send_request(input logic kind, input logic [2:0] jnt,
                              input logic [31:0] start_a, input logic [31:0] end_a,
                              input logic [11:0] step);
    logic [IN_TDATA_W-1:0] data;
    data = {1'b0, step, end_a, start_a, jnt};
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, data);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Wait until every expected angle has arrived and the block has settled.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_angles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_profile(input logic [31:0] total, input logic [31:0] accel,
                             input logic [31:0] decel, input logic [31:0] coef,
                             input logic [31:0] rate, input logic [31:0] base);
    write_reg(CFG_TOTAL, total);
    write_reg(CFG_ACCEL_END, accel);
    write_reg(CFG_DECEL_BEG, decel);
    write_reg(CFG_COEF, coef);
    write_reg(CFG_RATE, rate);
    write_reg(CFG_INTERCEPT, base);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic longint unsigned active_len();
    return (sb.move_len > MAX_STEPS) ? MAX_STEPS : sb.move_len;
  endfunction

  // Step inside the move, biased toward the phase boundaries.
  function automatic logic [11:0] pick_step();
    longint n;
    longint cand;
    n = active_len();
    if (n == 0) return 12'($urandom);
    case ($urandom_range(0, 9))
      0:       cand = sb.ramp_end;
      1:       cand = longint'(sb.ramp_end) - 1;
      2:       cand = sb.brake_start;
      3:       cand = longint'(sb.brake_start) - 1;
      4:       cand = n - 1;
      5:       cand = 0;
      default: cand = $urandom_range(0, 32'(n - 1));
    endcase
    if (cand < 0 || cand >= n) cand = $urandom_range(0, 32'(n - 1));
    return cand[11:0];
  endfunction

  // Random profile for one move; the first few are fixed corner settings.
  task automatic choose_profile(input int idx);
    logic [31:0] total;
    logic [31:0] accel;
    logic [31:0] decel;
    logic [31:0] base;
    case (idx)
      // Empty move: every tick lies past the end.
      0: set_profile(0, 0, 0, $urandom, $urandom, 0);
      // Oversized total is clamped; everything is ramp down.
      1: set_profile(13'h1FFF, 0, 0, $urandom >> $urandom_range(0, 8), 0, 0);
      // Ramp-down start ahead of ramp-up end.
      2: set_profile(3000, 2500, 600, $urandom >> $urandom_range(0, 4),
                     $urandom_range(0, 32'h0004_0000), 32'h2000_0000);
      // Pure cruise from the lowest intercept at a rate of 1.0 per step.
      3: set_profile(4096, 0, 4096, 0, 32'h4000_0000, 32'h8000_0000);
      // Single-point move.
      4: set_profile(1, 0, 1, $urandom, $urandom, $urandom);
      default: begin
        total = ($urandom_range(0, 4) == 0) ? 4096 : $urandom_range(1, 4096);
        accel = $urandom_range(0, total);
        decel = ($urandom_range(0, 4) == 0) ? $urandom_range(0, accel)
                                            : $urandom_range(accel, total);
        base  = $urandom_range(0, 1) ? $urandom_range(0, 32'h4000_0000)
                                     : -$urandom_range(0, 32'h8000_0000);
        set_profile(total, accel, decel, $urandom >> $urandom_range(0, 16),
                    $urandom_range(0, 32'h4000_0000) >> $urandom_range(0, 24), base);
      end
    endcase
  endtask

  // One move: load every joint, then mostly ticks with some noise.
  task automatic run_move(input int count);
    int          pick;
    logic [2:0]  jnt;
    logic [11:0] step;
    for (int j = 0; j < JOINTS_DEF; j++)
      send_request(REQ_LOAD, j[2:0], rand_angle(), rand_angle(), 12'($urandom));
    for (int i = JOINTS_DEF; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        jnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
        send_request(REQ_LOAD, jnt, rand_angle(), rand_angle(), 12'($urandom));
      end else if (pick == 2 && active_len() < MAX_STEPS) begin
        step = 12'($urandom_range(32'(active_len()), MAX_STEPS - 1));
        send_request(REQ_TICK, 3'($urandom), $urandom, $urandom, step);
      end else begin
        send_request(REQ_TICK, 3'($urandom), $urandom, $urandom, pick_step());
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default profile: endpoint extremes, joints out of range, phase edges.
    send_request(REQ_LOAD, 3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 12'd0);
    send_request(REQ_LOAD, 3'd1, 32'h7FFF_FFFF, 32'h8000_0000, 12'hFFF);
    send_request(REQ_LOAD, 3'd2, 32'h0000_0000, 32'h0000_0000, 12'd0);
    send_request(REQ_LOAD, 3'd3, 32'hFFFF_FFFF, 32'h0000_0001, 12'd0);
    send_request(REQ_LOAD, 3'd4, 32'h5555_5555, 32'hAAAA_AAAA, 12'd0);
    send_request(REQ_LOAD, 3'd5, 32'hAAAA_AAAA, 32'h5555_5555, 12'd0);
    send_request(REQ_LOAD, 3'd6, 32'h1234_5678, 32'h0000_0000, 12'd0);
    send_request(REQ_LOAD, 3'd7, 32'h0000_0000, 32'h1234_5678, 12'd0);
    send_request(REQ_TICK, 3'd0, 32'h0, 32'h0, 12'd0);
    send_request(REQ_TICK, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd199);
    send_request(REQ_TICK, 3'd0, 32'h0, 32'h0, 12'd200);
    send_request(REQ_TICK, 3'd0, 32'h0, 32'h0, 12'd799);
    send_request(REQ_TICK, 3'd0, 32'h0, 32'h0, 12'd800);
    send_request(REQ_TICK, 3'd0, 32'h0, 32'h0, 12'd999);
    send_request(REQ_TICK, 3'd0, 32'h0, 32'h0, 12'd1000);
    send_request(REQ_TICK, 3'd0, 32'h0, 32'h0, 12'hFFF);
    drain();

    // Writes to indexes that do not exist, then the extreme profile.
    write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
    set_profile(4096, 1024, 3072, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(REQ_TICK, 3'd0, 32'h0, 32'h0, 12'd0);
    send_request(REQ_TICK, 3'd0, 32'h0, 32'h0, 12'd1023);
    send_request(REQ_TICK, 3'd0, 32'h0, 32'h0, 12'd1024);
    send_request(REQ_TICK, 3'd0, 32'h0, 32'h0, 12'd3071);
    send_request(REQ_TICK, 3'd0, 32'h0, 32'h0, 12'd3072);
    send_request(REQ_TICK, 3'd0, 32'h0, 32'h0, 12'hFFF);
    drain();

    // Random moves; the last one runs with both sides always ready.
    for (int m = 0; m < MOVES; m++) begin
      choose_profile(m);
      quiet = (m == MOVES - 1);
      run_move(MOVE_ITEMS);
      drain();
    end

    if (sb.failures == 0 && sb.pending_angles.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== joint_space_profile_interpolator_top.f =====
design/jspi_pkg.sv
design/jspi_seq.sv
design/joint_space_profile_interpolator_top.sv
design/jspi_chk.sv
tb/tb_joint_space_profile_interpolator_top.sv
